### rtl/cubic_bezier_point_tangent_unit_assert.svh
// Assertion macros used by the checker of the cubic Bezier unit.
`ifndef CUBIC_BEZIER_POINT_TANGENT_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_POINT_TANGENT_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CBZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbz implication violated");

// Invariant checked on every rising clock edge outside reset.
`define CBZ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cbz invariant violated");

`endif

### rtl/cbz_pkg.sv
// Shared types and constants of the cubic Bezier point and tangent unit.
`default_nettype none

package cbz_pkg;

  localparam int unsigned CoordW   = 24;                 // control point and point width
  localparam int unsigned TW       = 17;                 // parameter width, Q0.16 plus one
  localparam int unsigned FracT    = TW - 1;             // fraction bits of t
  localparam int unsigned BW       = CoordW + 2 * FracT; // second level lerp width
  localparam int unsigned DerivW   = 27;                 // derivative width
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned PipeLat  = 7;                  // start transfer to done strobe
  localparam logic [TW-1:0] TOne   = TW'(1) << FracT;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CTRL0_X = 4'd0,
    REG_CTRL0_Y = 4'd1,
    REG_CTRL1_X = 4'd2,
    REG_CTRL1_Y = 4'd3,
    REG_CTRL2_X = 4'd4,
    REG_CTRL2_Y = 4'd5,
    REG_CTRL3_X = 4'd6,
    REG_CTRL3_Y = 4'd7
  } cbz_reg_e;

  // Control word that travels alongside each stage's data.
  typedef struct packed {
    logic          vld;
    logic [TW-1:0] t;
    logic [TW-1:0] u;
  } cbz_ctl_t;

endpackage

`default_nettype wire

### rtl/cbz_lerp.sv
// One de Casteljau level: out[k] = in[k]*u + in[k+1]*t, multiply stage then add stage.
`default_nettype none

module cbz_lerp
  import cbz_pkg::*;
#(
  parameter int unsigned InW    = CoordW,
  parameter int unsigned NumOut = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cbz_ctl_t                    ctl_i,
  input  logic signed [InW-1:0]       x_i [NumOut+1],
  input  logic signed [InW-1:0]       y_i [NumOut+1],
  output cbz_ctl_t                    ctl_o,
  output logic signed [InW+FracT-1:0] x_o [NumOut],
  output logic signed [InW+FracT-1:0] y_o [NumOut]
);

  localparam int unsigned ProdW = InW + TW + 1;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned OutW  = InW + FracT;

  logic signed [TW:0]      t_s, u_s;
  logic signed [ProdW-1:0] xu_d [NumOut];
  logic signed [ProdW-1:0] xt_d [NumOut];
  logic signed [ProdW-1:0] yu_d [NumOut];
  logic signed [ProdW-1:0] yt_d [NumOut];
  logic signed [ProdW-1:0] xu_q [NumOut];
  logic signed [ProdW-1:0] xt_q [NumOut];
  logic signed [ProdW-1:0] yu_q [NumOut];
  logic signed [ProdW-1:0] yt_q [NumOut];
  logic signed [SumW-1:0]  xs_d [NumOut];
  logic signed [SumW-1:0]  ys_d [NumOut];
  logic signed [OutW-1:0]  x_q  [NumOut];
  logic signed [OutW-1:0]  y_q  [NumOut];
  cbz_ctl_t                ctl_a_q, ctl_b_q;

  assign t_s = $signed({1'b0, ctl_i.t});
  assign u_s = $signed({1'b0, ctl_i.u});

  always_comb begin
    for (int k = 0; k < NumOut; k++) begin
      xu_d[k] = x_i[k]   * u_s;
      xt_d[k] = x_i[k+1] * t_s;
      yu_d[k] = y_i[k]   * u_s;
      yt_d[k] = y_i[k+1] * t_s;
      xs_d[k] = SumW'(xu_q[k]) + SumW'(xt_q[k]);
      ys_d[k] = SumW'(yu_q[k]) + SumW'(yt_q[k]);
    end
  end

  // Products and partial sums carry no reset; only the control words do.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumOut; k++) begin
      xu_q[k] <= xu_d[k];
      xt_q[k] <= xt_d[k];
      yu_q[k] <= yu_d[k];
      yt_q[k] <= yt_d[k];
      // convex combination: exact in OutW bits
      x_q[k]  <= xs_d[k][OutW-1:0];
      y_q[k]  <= ys_d[k][OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  assign ctl_o = ctl_b_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule

`default_nettype wire

### rtl/cbz_deriv.sv
// Tangent from the last de Casteljau pair: floor(3 * (b1 - b0) / 2^32), two stages.
`default_nettype none

module cbz_deriv
  import cbz_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [BW-1:0]     bx_i [2],
  input  logic signed [BW-1:0]     by_i [2],
  output logic signed [DerivW-1:0] deriv_x_o,
  output logic signed [DerivW-1:0] deriv_y_o
);

  localparam int unsigned DiffW = BW + 1;
  localparam int unsigned TriW  = BW + 3;

  logic signed [DiffW-1:0]  dx_q, dy_q;
  logic signed [TriW-1:0]   tx_d, ty_d;
  logic signed [DerivW-1:0] deriv_x_q, deriv_y_q;

  // 3*d as d + 2d; floor by dropping the low bits of a two's complement value
  assign tx_d = TriW'(dx_q) + (TriW'(dx_q) <<< 1);
  assign ty_d = TriW'(dy_q) + (TriW'(dy_q) <<< 1);

  always_ff @(posedge clk_i) begin
    dx_q      <= DiffW'(bx_i[1]) - DiffW'(bx_i[0]);
    dy_q      <= DiffW'(by_i[1]) - DiffW'(by_i[0]);
    deriv_x_q <= tx_d[TriW-1:2*FracT];
    deriv_y_q <= ty_d[TriW-1:2*FracT];
  end

  assign deriv_x_o = deriv_x_q;
  assign deriv_y_o = deriv_y_q;

endmodule

`default_nettype wire

### rtl/cubic_bezier_point_tangent_unit.sv
// Top level of the cubic Bezier point and tangent unit.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  command  | start_i / busy_o       | t_param_i
//  result   | done_o (strobe)        | point_x_o, point_y_o, deriv_x_o, deriv_y_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item enters per clock; busy_o stays low. After its start transfer each item passes
// through one input stage, then three lerp levels of a multiply stage and an add stage
// each, with the tangent built beside the last level.
// Reset clears the control points and all valid bits. Results are strobed for one
// cycle and cannot be held off; nothing in the pipe ever waits.
`default_nettype none

module cubic_bezier_point_tangent_unit
  import cbz_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [TW-1:0]            t_param_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] point_x_o,
  output logic signed [CoordW-1:0] point_y_o,
  output logic signed [DerivW-1:0] deriv_x_o,
  output logic signed [DerivW-1:0] deriv_y_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic signed [CoordW-1:0] cfg_data_i
);

  localparam int unsigned AW = CoordW + FracT;
  localparam int unsigned PW = BW + FracT;

  logic signed [CoordW-1:0] ctrl_q [NumRegs];
  logic signed [CoordW-1:0] p_x [4];
  logic signed [CoordW-1:0] p_y [4];
  logic signed [AW-1:0]     a_x [3];
  logic signed [AW-1:0]     a_y [3];
  logic signed [BW-1:0]     b_x [2];
  logic signed [BW-1:0]     b_y [2];
  logic signed [PW-1:0]     c_x [1];
  logic signed [PW-1:0]     c_y [1];
  logic [TW-1:0]            t_sat;
  cbz_ctl_t                 ctl0_d, ctl0_q, ctl1, ctl2, ctl3;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        ctrl_q[i] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i <= REG_CTRL3_Y)) begin
      ctrl_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p_x[k] = ctrl_q[2*k];
      p_y[k] = ctrl_q[2*k+1];
    end
  end

  // Clamp t to one and form u = 1 - t.
  assign t_sat      = (t_param_i > TOne) ? TOne : t_param_i;
  assign ctl0_d.vld = start_i && !busy_o;
  assign ctl0_d.t   = t_sat;
  assign ctl0_d.u   = TOne - t_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl0_d;
    end
  end

  cbz_lerp #(.InW(CoordW), .NumOut(3)) u_lerp1 (
    .clk_i, .rst_ni,
    .ctl_i(ctl0_q), .x_i(p_x), .y_i(p_y),
    .ctl_o(ctl1),   .x_o(a_x), .y_o(a_y)
  );

  cbz_lerp #(.InW(AW), .NumOut(2)) u_lerp2 (
    .clk_i, .rst_ni,
    .ctl_i(ctl1), .x_i(a_x), .y_i(a_y),
    .ctl_o(ctl2), .x_o(b_x), .y_o(b_y)
  );

  cbz_lerp #(.InW(BW), .NumOut(1)) u_lerp3 (
    .clk_i, .rst_ni,
    .ctl_i(ctl2), .x_i(b_x), .y_i(b_y),
    .ctl_o(ctl3), .x_o(c_x), .y_o(c_y)
  );

  cbz_deriv u_deriv (
    .clk_i,
    .bx_i(b_x), .by_i(b_y),
    .deriv_x_o, .deriv_y_o
  );

  // Point sits at scale 2^48; floor by taking the top bits.
  assign point_x_o = c_x[0][PW-1:3*FracT];
  assign point_y_o = c_y[0][PW-1:3*FracT];
  assign done_o    = ctl3.vld;

endmodule

`default_nettype wire

### rtl/cbz_checker.sv
// Port-level checker for the cubic Bezier unit, bound to the top level.
`default_nettype none
`include "cubic_bezier_point_tangent_unit_assert.svh"

module cbz_checker
  import cbz_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic signed [DerivW-1:0] deriv_x_o,
  input logic signed [DerivW-1:0] deriv_y_o
);

  localparam logic signed [DerivW-1:0] DerivMax = DerivW'(3 * (1 << CoordW));

  // Every strobe traces back to a start transfer a fixed latency earlier.
  `CBZ_ASSERT_IMP(a_done_has_start, clk_i, rst_ni, done_o, $past(start_i && !busy_o, PipeLat))

  // Tangent magnitude stays below three times the coordinate span.
  `CBZ_ASSERT_IMP(a_deriv_x_range, clk_i, rst_ni, done_o, (deriv_x_o < DerivMax) && (deriv_x_o > -DerivMax))
  `CBZ_ASSERT_IMP(a_deriv_y_range, clk_i, rst_ni, done_o, (deriv_y_o < DerivMax) && (deriv_y_o > -DerivMax))

  // Command side never pushes back.
  `CBZ_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o)

endmodule

bind cubic_bezier_point_tangent_unit cbz_checker u_cbz_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .done_o    (done_o),
  .deriv_x_o (deriv_x_o),
  .deriv_y_o (deriv_y_o)
);

`default_nettype wire

### tb/sv/cubic_bezier_point_tangent_unit_tb.sv
// Self-checking testbench for the cubic Bezier point and tangent unit.
module cubic_bezier_point_tangent_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbz_pkg::*;

  localparam int unsigned AccW        = 96;  // wide enough for every exact sum of products
  localparam int signed   DerivGain   = 3;   // cubic tangent weight
  localparam int unsigned ItemsPerSet = 88;
  localparam int unsigned NumSets     = 8;
  localparam int unsigned DrainCycles = 4 * PipeLat + 16;
  localparam int unsigned MaxPrints   = 30;
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [TW-1:0] TAllOnes = '1;

  typedef enum int unsigned {
    CURVE_RANDOM,
    CURVE_MAX,
    CURVE_MIN,
    CURVE_ZIGZAG,
    CURVE_NEAR
  } curve_mode_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [DerivW-1:0] deriv_x;
    logic signed [DerivW-1:0] deriv_y;
  } curve_sample_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point;
    logic signed [DerivW-1:0] deriv;
  } axis_value_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]       idx;
    logic signed [CoordW-1:0] data;
  } reg_write_t;

  class bezier_scoreboard;
    logic signed [CoordW-1:0] ctrl [NumRegs];
    curve_sample_t            expected_q [$];
    int unsigned              failures;
    int unsigned              checked;

    function new();
      foreach (ctrl[i]) ctrl[i] = '0;
      failures = 0;
      checked  = 0;
    endfunction

    task report_mismatch(input string what);
      failures++;
      if (failures <= MaxPrints) $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Indexes past the last control point are dropped by the block.
    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic signed [CoordW-1:0] data);
      if (idx < NumRegs) ctrl[idx[RegIdxW-1:0]] = data;
    endfunction

    // Exact de Casteljau evaluation of one axis, floored once.
    function axis_value_t eval_axis(input logic signed [CoordW-1:0] c [4], input logic [TW-1:0] t);
      logic signed [AccW-1:0] tt, uu, b0, b1, acc;
      logic signed [AccW-1:0] a [3];
      axis_value_t res;
      tt = $signed({1'b0, (t > TOne) ? TOne : t});
      uu = $signed({1'b0, TOne}) - tt;
      for (int i = 0; i < 3; i++) a[i] = c[i] * uu + c[i+1] * tt;
      b0 = a[0] * uu + a[1] * tt;
      b1 = a[1] * uu + a[2] * tt;
      acc = (DerivGain * (b1 - b0)) >>> (2 * FracT);
      res.deriv = acc[DerivW-1:0];
      acc = (b0 * uu + b1 * tt) >>> (3 * FracT);
      res.point = acc[CoordW-1:0];
      return res;
    endfunction

    function void note_sample(input logic [TW-1:0] t);
      logic signed [CoordW-1:0] xs [4];
      logic signed [CoordW-1:0] ys [4];
      axis_value_t vx, vy;
      curve_sample_t s;
      for (int i = 0; i < 4; i++) begin
        xs[i] = ctrl[2*i];
        ys[i] = ctrl[2*i+1];
      end
      vx = eval_axis(xs, t);
      vy = eval_axis(ys, t);
      s.point_x = vx.point;
      s.point_y = vy.point;
      s.deriv_x = vx.deriv;
      s.deriv_y = vy.deriv;
      expected_q.insert(expected_q.size(), s);
    endfunction

    task check_result(input curve_sample_t got);
      curve_sample_t exp_s;
      longint g [4];
      longint e [4];
      string names [4];
      names = '{"point_x", "point_y", "deriv_x", "deriv_y"};
      if (expected_q.size() == 0) begin
        report_mismatch("result strobed with no sample outstanding");
      end else begin
        exp_s = expected_q.pop_front();
        checked++;
        g = '{got.point_x, got.point_y, got.deriv_x, got.deriv_y};
        e = '{exp_s.point_x, exp_s.point_y, exp_s.deriv_x, exp_s.deriv_y};
        for (int i = 0; i < 4; i++)
          if (g[i] !== e[i])
            report_mismatch($sformatf("%s got %0d expected %0d", names[i], g[i], e[i]));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task flush_leftovers();
      while (expected_q.size() != 0) begin
        void'(expected_q.pop_front());
        report_mismatch("expected result never arrived");
      end
    endtask
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start_i     = 1'b0;
  logic                     busy_o;
  logic [TW-1:0]            t_param_i   = '0;
  logic                     done_o;
  logic signed [CoordW-1:0] point_x_o;
  logic signed [CoordW-1:0] point_y_o;
  logic signed [DerivW-1:0] deriv_x_o;
  logic signed [DerivW-1:0] deriv_y_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic signed [CoordW-1:0] cfg_data_i  = '0;

  bezier_scoreboard sb = new();
  int unsigned samples_sent  = 0;
  int unsigned curves_loaded = 0;

  cubic_bezier_point_tangent_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .t_param_i   (t_param_i),
    .done_o      (done_o),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .deriv_x_o   (deriv_x_o),
    .deriv_y_o   (deriv_y_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("cubic_bezier_point_tangent_unit_tb NOT OK");
    $finish;
  end

  // Results cannot be held off: take each strobed one at the edge ending its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      sb.check_result('{point_x_o, point_y_o, deriv_x_o, deriv_y_o});
  end

  function automatic logic signed [CoordW-1:0] pick_coord(input curve_mode_e mode,
                                                          input int unsigned idx);
    logic [31:0] r;
    r = $urandom;
    case (mode)
      CURVE_MAX:    return CoordMax;
      CURVE_MIN:    return CoordMin;
      // alternate extremes along the hull, y in opposite phase to x
      CURVE_ZIGZAG: return (((idx / 2) + (idx % 2)) % 2) ? CoordMax : CoordMin;
      CURVE_NEAR:   return $signed(r[CoordW-1:0]) >>> 12;
      default:      return r[CoordW-1:0];
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_t();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return TW'(1);
        2:       return TOne - TW'(1);
        default: return TOne;
      endcase
    end
    if (r < 18) return TW'($urandom_range(TOne + 1, TAllOnes));
    return TW'($urandom_range(0, TOne));
  endfunction

  // Load all control points in random order, optionally with writes to unused indexes mixed in.
  task automatic load_curve(input curve_mode_e mode, input bit with_junk);
    reg_write_t writes [$];
    reg_write_t w;
    int unsigned order [$];
    int unsigned pos;
    for (int i = 0; i < NumRegs; i++) order.insert(order.size(), i);
    while (order.size() != 0) begin
      pos = $urandom_range(order.size() - 1);
      w.idx  = cbz_reg_e'(order[pos]);
      w.data = pick_coord(mode, order[pos]);
      writes.insert(writes.size(), w);
      order.delete(pos);
    end
    if (with_junk) begin
      for (int i = 0; i < 2; i++) begin
        w.idx  = CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1));
        w.data = CoordW'($urandom);
        writes.insert($urandom_range(writes.size()), w);
      end
    end
    foreach (writes[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= writes[i].idx;
      cfg_data_i  <= writes[i].data;
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      sb.write_reg(writes[i].idx, writes[i].data);
    end
    cfg_valid_i <= 1'b0;
    curves_loaded++;
  endtask

  task automatic send_sample(input logic [TW-1:0] t, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    t_param_i <= t;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_sample(t);
    samples_sent++;
  endtask

  // Hold the command side quiet until every outstanding result is back or the drain limit runs out.
  task automatic drain_results();
    start_i <= 1'b0;
    for (int n = 0; n < DrainCycles && sb.pending() != 0; n++) @(posedge clk_i);
    sb.flush_leftovers();
  endtask

  initial begin
    logic [TW-1:0] edge_ts [8];
    int unsigned idle_pcts [3];
    curve_mode_e modes [5];
    edge_ts   = '{'0, TW'(1), TOne >> 1, TOne - TW'(1), TOne, TOne + TW'(1), TAllOnes,
                  TW'(21845)};
    idle_pcts = '{0, 71, 26};
    modes     = '{CURVE_RANDOM, CURVE_ZIGZAG, CURVE_NEAR, CURVE_MAX, CURVE_MIN};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: every control point at the origin
    for (int i = 0; i < 3; i++) send_sample(edge_ts[2*i], 0);
    drain_results();

    load_curve(CURVE_ZIGZAG, 1'b1);
    foreach (edge_ts[i]) send_sample(edge_ts[i], 0);
    drain_results();
    load_curve(CURVE_MAX, 1'b0);
    for (int i = 0; i < 4; i++) send_sample(edge_ts[2*i+1], 0);
    drain_results();
    load_curve(CURVE_MIN, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(edge_ts[2*i], 0);
    drain_results();

    for (int s = 0; s < NumSets; s++) begin
      load_curve(modes[s % 5], s[0]);
      for (int i = 0; i < ItemsPerSet; i++) begin
        // leave some stretches without gaps inside the idling sets
        send_sample(pick_t(), ((i / 20) % 2) ? 0 : idle_pcts[s % 3]);
      end
      drain_results();
    end

    repeat (PipeLat + 4) @(posedge clk_i);

    $display("Swept %0d parameter samples across %0d control point sets, t past one included.",
             samples_sent, curves_loaded);
    $display("Checked %0d point and tangent results, %0d mismatches.", sb.checked, sb.failures);
    if (sb.failures == 0) begin
      $display("cubic_bezier_point_tangent_unit_tb OK");
    end else begin
      $display("cubic_bezier_point_tangent_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/cbz_pkg.sv
rtl/cbz_lerp.sv
rtl/cbz_deriv.sv
rtl/cubic_bezier_point_tangent_unit.sv
rtl/cbz_checker.sv
tb/sv/cubic_bezier_point_tangent_unit_tb.sv
